>>> hdl/etl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etl_pkg - shared types and constants of the expression lexer
// token kinds, character codes, token and queue entry formats
// ----------------------------------------------------------------------------
package etl_pkg;

  localparam int POSITION_BITS = 16;
  localparam int LENGTH_BITS   = 8;
  localparam int CHAR_BITS     = 8;
  localparam int KIND_BITS     = 4;
  localparam int IN_DATA_BITS  = ((CHAR_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((KIND_BITS + POSITION_BITS + LENGTH_BITS + 7) / 8) * 8;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  localparam logic [CHAR_BITS-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_BITS-1:0] CH_EQ     = 8'h3D;
  localparam logic [CHAR_BITS-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_BITS-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_BITS-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_BITS-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_BITS-1:0] CH_GT     = 8'h3E;
  localparam logic [CHAR_BITS-1:0] CH_LT     = 8'h3C;
  localparam logic [CHAR_BITS-1:0] CH_BANG   = 8'h21;
  localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LO_Z   = 8'h7A;
  localparam logic [CHAR_BITS-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UP_Z   = 8'h5A;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_NUMBER = 4'd0,
    KIND_IDENT  = 4'd1,
    KIND_ASSIGN = 4'd2,
    KIND_PLUS   = 4'd3,
    KIND_MINUS  = 4'd4,
    KIND_STAR   = 4'd5,
    KIND_SLASH  = 4'd6,
    KIND_LPAREN = 4'd7,
    KIND_RPAREN = 4'd8,
    KIND_GE     = 4'd9,
    KIND_LE     = 4'd10,
    KIND_GT     = 4'd11,
    KIND_LT     = 4'd12,
    KIND_NE     = 4'd13,
    KIND_BANG   = 4'd14
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [POSITION_BITS-1:0] start;
    logic [LENGTH_BITS-1:0]   length;
  } token_t;

  // one queue entry: the tokens caused by one input beat
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } bundle_t;

endpackage

>>> hdl/etl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etl_front - character classifier and lexer state
// takes one character a beat, updates the open token and queues the tokens
// that the character closes or completes
// ----------------------------------------------------------------------------
module etl_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [etl_pkg::IN_DATA_BITS-1:0]  s_tdata,
  input  logic                              s_tlast,
  input  logic                              q_full,
  output logic                              q_push,
  output etl_pkg::bundle_t                  q_data
);

  typedef enum logic [2:0] {
    MD_IDLE    = 3'd0,
    MD_NUM     = 3'd1,
    MD_NUM_DOT = 3'd2,
    MD_IDENT   = 3'd3,
    MD_GT      = 3'd4,
    MD_LT      = 3'd5,
    MD_BANG    = 3'd6
  } mode_t;

  function automatic etl_pkg::kind_t mode_kind(input mode_t m);
    etl_pkg::kind_t k;
    unique case (m)
      MD_NUM, MD_NUM_DOT: k = etl_pkg::KIND_NUMBER;
      MD_IDENT:           k = etl_pkg::KIND_IDENT;
      MD_GT:              k = etl_pkg::KIND_GT;
      MD_LT:              k = etl_pkg::KIND_LT;
      default:            k = etl_pkg::KIND_BANG;
    endcase
    return k;
  endfunction

  function automatic logic mode_open(input mode_t m);
    return (m == MD_NUM) || (m == MD_NUM_DOT) || (m == MD_IDENT) ||
           (m == MD_GT) || (m == MD_LT) || (m == MD_BANG);
  endfunction

  mode_t                              mode, mode_mid, mode_next;
  logic [etl_pkg::POSITION_BITS-1:0]  open_start, start_mid, open_start_next;
  logic [etl_pkg::LENGTH_BITS-1:0]    open_length, len_mid, open_length_next, len_inc;
  logic [etl_pkg::POSITION_BITS-1:0]  char_position, char_position_next;

  logic [etl_pkg::CHAR_BITS-1:0] ch;
  logic is_dig, is_let, is_dot, is_eq, is_single;
  etl_pkg::kind_t single_kind, eq_kind;
  logic taken, emit_eq, close_v, second_v, flush_v;
  etl_pkg::token_t close_tok, second_tok;
  logic accept;

  assign ch       = s_tdata[etl_pkg::CHAR_BITS-1:0];
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  assign is_dig = (ch >= etl_pkg::CH_ZERO) && (ch <= etl_pkg::CH_NINE);
  assign is_let = ((ch >= etl_pkg::CH_LO_A) && (ch <= etl_pkg::CH_LO_Z)) ||
                  ((ch >= etl_pkg::CH_UP_A) && (ch <= etl_pkg::CH_UP_Z));
  assign is_dot = (ch == etl_pkg::CH_DOT);
  assign is_eq  = (ch == etl_pkg::CH_EQ);

  always_comb begin
    is_single   = 1'b1;
    single_kind = etl_pkg::KIND_ASSIGN;
    unique case (ch)
      etl_pkg::CH_EQ:     single_kind = etl_pkg::KIND_ASSIGN;
      etl_pkg::CH_PLUS:   single_kind = etl_pkg::KIND_PLUS;
      etl_pkg::CH_MINUS:  single_kind = etl_pkg::KIND_MINUS;
      etl_pkg::CH_STAR:   single_kind = etl_pkg::KIND_STAR;
      etl_pkg::CH_SLASH:  single_kind = etl_pkg::KIND_SLASH;
      etl_pkg::CH_LPAREN: single_kind = etl_pkg::KIND_LPAREN;
      etl_pkg::CH_RPAREN: single_kind = etl_pkg::KIND_RPAREN;
      default:            is_single = 1'b0;
    endcase
  end

  always_comb begin
    mode_mid  = MD_IDLE;
    start_mid = open_start;
    len_mid   = open_length;
    taken     = 1'b0;
    emit_eq   = 1'b0;
    eq_kind   = etl_pkg::KIND_GE;
    len_inc   = (open_length == etl_pkg::LEN_MAX) ? open_length
                                                  : open_length + 1'b1;
    unique case (mode)
      MD_NUM, MD_NUM_DOT: begin
        if (is_dig || (is_dot && (mode == MD_NUM))) begin
          taken    = 1'b1;
          len_mid  = len_inc;
          mode_mid = is_dot ? MD_NUM_DOT : mode;
        end
      end
      MD_IDENT: begin
        if (is_dig || is_let) begin
          taken    = 1'b1;
          len_mid  = len_inc;
          mode_mid = MD_IDENT;
        end
      end
      MD_GT, MD_LT, MD_BANG: begin
        if (is_eq) begin
          taken   = 1'b1;
          emit_eq = 1'b1;
          eq_kind = (mode == MD_GT) ? etl_pkg::KIND_GE :
                    (mode == MD_LT) ? etl_pkg::KIND_LE : etl_pkg::KIND_NE;
        end
      end
      default: ;
    endcase

    // token closed by this character, or the two-character comparison
    close_v = emit_eq || (!taken && mode_open(mode));
    if (emit_eq) begin
      close_tok.kind   = eq_kind;
      close_tok.start  = open_start;
      close_tok.length = etl_pkg::LENGTH_BITS'(2);
    end else begin
      close_tok.kind   = mode_kind(mode);
      close_tok.start  = open_start;
      close_tok.length = open_length;
    end

    if (!taken) begin
      if (is_dig || is_let || (ch == etl_pkg::CH_GT) || (ch == etl_pkg::CH_LT) ||
          (ch == etl_pkg::CH_BANG)) begin
        mode_mid  = is_dig ? MD_NUM : is_let ? MD_IDENT :
                    (ch == etl_pkg::CH_GT) ? MD_GT :
                    (ch == etl_pkg::CH_LT) ? MD_LT : MD_BANG;
        start_mid = char_position;
        len_mid   = etl_pkg::LENGTH_BITS'(1);
      end
    end

    flush_v  = s_tlast && mode_open(mode_mid);
    second_v = (!taken && is_single) || flush_v;
    if (!taken && is_single) begin
      second_tok.kind   = single_kind;
      second_tok.start  = char_position;
      second_tok.length = etl_pkg::LENGTH_BITS'(1);
    end else begin
      second_tok.kind   = mode_kind(mode_mid);
      second_tok.start  = start_mid;
      second_tok.length = len_mid;
    end

    if (s_tlast) begin
      mode_next          = MD_IDLE;
      open_start_next    = '0;
      open_length_next   = '0;
      char_position_next = '0;
    end else begin
      mode_next          = mode_mid;
      open_start_next    = start_mid;
      open_length_next   = len_mid;
      char_position_next = char_position + 1'b1;
    end
  end

  assign q_push      = accept && (close_v || second_v);
  assign q_data.two  = close_v && second_v;
  assign q_data.tok0 = close_v ? close_tok : second_tok;
  assign q_data.tok1 = second_tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MD_IDLE;
      open_start    <= '0;
      open_length   <= '0;
      char_position <= '0;
    end else if (accept) begin
      mode          <= mode_next;
      open_start    <= open_start_next;
      open_length   <= open_length_next;
      char_position <= char_position_next;
    end
  end

endmodule

>>> hdl/etl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etl_queue - short token queue between lexer and output side
// register-based fifo of token bundles
// ----------------------------------------------------------------------------
module etl_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  etl_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             avail,
  output etl_pkg::bundle_t head
);

  etl_pkg::bundle_t                      entries [etl_pkg::QUEUE_DEPTH];
  logic [etl_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr, rd_ptr;
  logic [etl_pkg::QUEUE_PTR_BITS:0]      count;

  assign full  = (count == (etl_pkg::QUEUE_PTR_BITS + 1)'(etl_pkg::QUEUE_DEPTH));
  assign avail = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

>>> hdl/etl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etl_back - token output side
// splits queued bundles into single token beats behind an output register
// ----------------------------------------------------------------------------
module etl_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_avail,
  input  etl_pkg::bundle_t                  q_head,
  output logic                              q_pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [etl_pkg::OUT_DATA_BITS-1:0] m_tdata,
  output logic                              m_tlast
);

  logic            out_valid, out_last, sec_valid;
  etl_pkg::token_t out_tok, sec_tok;
  logic            load;

  assign load  = !out_valid || m_tready;
  assign q_pop = load && !sec_valid && q_avail;

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = etl_pkg::OUT_DATA_BITS'({out_tok.length, out_tok.start, out_tok.kind});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sec_valid <= 1'b0;
    end else if (load) begin
      if (sec_valid) begin
        out_valid <= 1'b1;
        sec_valid <= 1'b0;
      end else if (q_avail) begin
        out_valid <= 1'b1;
        sec_valid <= q_head.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (sec_valid) begin
        out_tok  <= sec_tok;
        out_last <= 1'b1;
      end else if (q_avail) begin
        out_tok  <= q_head.tok0;
        out_last <= !q_head.two;
        sec_tok  <= q_head.tok1;
      end
    end
  end

endmodule

>>> hdl/expression_token_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_token_lexer - streaming lexer for arithmetic expressions
// one character a beat in, tokens (kind, start, length) out
//
//   channel  dir  tdata                          tuser  tlast
//   s        in   character                      -      is_end
//   m        out  token_kind, start, length      -      last_of_run
//
// one character accepted per cycle while the token queue has room
// each token is sent as its own output beat; a character closing two tokens gives two beats
// an accepted character's tokens pass through the queue and then the output register
// rst clears lexer state and empties the queue and the output register
// either side may stall; the four-entry queue absorbs the difference
// ----------------------------------------------------------------------------
module expression_token_lexer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [etl_pkg::IN_DATA_BITS-1:0]  s_tdata,   // character
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [etl_pkg::OUT_DATA_BITS-1:0] m_tdata,   // token_kind, token_start, token_length
  output logic                              m_tlast
);

  logic             q_push, q_full, q_pop, q_avail;
  etl_pkg::bundle_t q_data, q_head;

  etl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  etl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .head      (q_head)
  );

  etl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_avail  (q_avail),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
